[src/grid_same_colour_cycle_detect_macros.svh]
// ----------------------------------------------------------------------------
// grid_same_colour_cycle_detect_macros
// assertion macros shared by the grid cycle detector modules
// ----------------------------------------------------------------------------
`ifndef GRID_SAME_COLOUR_CYCLE_DETECT_MACROS_SVH
`define GRID_SAME_COLOUR_CYCLE_DETECT_MACROS_SVH
`ifndef SYNTHESIS
`define GSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GSC_ASSERT(label, clk, rst_n, prop, msg)
`define GSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/gscd_pkg.sv]
// ----------------------------------------------------------------------------
// gscd_pkg
// shared widths and codes for the grid cycle detector
// ----------------------------------------------------------------------------
`default_nettype none
package gscd_pkg;
    localparam int COLOUR_W = 5;
    localparam int DIM_W    = 7;
    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;
    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_DOWN  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;
endpackage
`default_nettype wire

[src/gscd_search.sv]
// ----------------------------------------------------------------------------
// gscd_search
// depth-first search engine over colour store, visited/on-path maps and stack
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_same_colour_cycle_detect_macros.svh"
module gscd_search #(
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [RW+CW-1:0]            wr_addr,
    input  wire logic [gscd_pkg::COLOUR_W-1:0] wr_colour,
    input  wire logic                        start,
    input  wire logic [RW:0]                 rows,
    input  wire logic [CW:0]                 cols,
    output logic                             done,
    output logic                             found
);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int SPW   = AW + 1;
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SCANW = 4'd3;
    localparam logic [3:0] S_TOPR  = 4'd4;
    localparam logic [3:0] S_TOPW  = 4'd5;
    localparam logic [3:0] S_NBRW  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // colour store, flag store (bit1 visited, bit0 on path), stack
    logic [gscd_pkg::COLOUR_W-1:0] col_mem [DEPTH];
    logic [1:0]                    flg_mem [DEPTH];
    logic [AW+2:0]                 stk_mem [DEPTH];

    logic [3:0]  state_reg, state_next;
    logic [RW-1:0] sr_reg, sr_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [gscd_pkg::COLOUR_W-1:0] colour_reg, colour_next;
    logic [RW-1:0] nr_reg, nr_next;
    logic [CW-1:0] nc_reg, nc_next;
    logic        found_reg, found_next;
    logic        done_reg, done_next;

    logic [AW-1:0] col_raddr, flg_addr, flg_waddr, stk_addr;
    logic          flg_we, stk_we;
    logic [1:0]    flg_wdata;
    logic [AW+2:0] stk_wdata;
    logic [gscd_pkg::COLOUR_W-1:0] col_rdata;
    logic [1:0]    flg_rdata;
    logic [AW+2:0] stk_rdata;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
        addr_of = {r, c};
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            col_mem[wr_addr] <= wr_colour;
        end
        col_rdata <= col_mem[col_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (flg_we)
        begin
            flg_mem[flg_waddr] <= flg_wdata;
        end
        flg_rdata <= flg_mem[flg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= stk_wdata;
        end
        stk_rdata <= stk_mem[stk_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
            sr_reg    <= '0;
            sc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            found_reg <= found_next;
            done_reg  <= done_next;
            sr_reg    <= sr_next;
            sc_reg    <= sc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        nr_reg <= nr_next;
        nc_reg <= nc_next;
    end

    logic last_r, last_c;
    logic blocked;
    logic [SPW-1:0] top;
    assign last_r = ({1'b0, sr_reg} + 1'b1) >= rows;
    assign last_c = ({1'b0, sc_reg} + 1'b1) >= cols;
    assign top    = sp_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        sr_next     = sr_reg;
        sc_next     = sc_reg;
        sp_next     = sp_reg;
        colour_next = colour_reg;
        nr_next     = nr_reg;
        nc_next     = nc_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        col_raddr   = addr_of(sr_reg, sc_reg);
        flg_addr    = addr_of(sr_reg, sc_reg);
        flg_waddr   = addr_of(sr_reg, sc_reg);
        flg_we      = 1'b0;
        flg_wdata   = 2'b00;
        stk_addr    = top[AW-1:0];
        stk_we      = 1'b0;
        stk_wdata   = '0;
        blocked     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sr_next   = '0;
                    sc_next   = '0;
                    found_next = 1'b0;
                    state_next = S_CLEAR;
                end
            end
            // clear flags of the active grid, one cell a cycle
            S_CLEAR:
            begin
                flg_we    = 1'b1;
                flg_wdata = 2'b00;
                if (last_c)
                begin
                    sc_next = '0;
                    if (last_r)
                    begin
                        sr_next    = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        sr_next = sr_reg + 1'b1;
                    end
                end
                else
                begin
                    sc_next = sc_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                if (!flg_rdata[1])
                begin
                    colour_next = col_rdata;
                    flg_we      = 1'b1;
                    flg_wdata   = 2'b11;
                    stk_addr    = '0;
                    stk_we      = 1'b1;
                    stk_wdata   = {sr_reg, sc_reg, gscd_pkg::DIR_UP};
                    sp_next     = SPW'(1);
                    state_next  = S_TOPR;
                end
                else if (last_c && last_r)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    if (last_c)
                    begin
                        sc_next = '0;
                        sr_next = sr_reg + 1'b1;
                    end
                    else
                    begin
                        sc_next = sc_reg + 1'b1;
                    end
                    state_next = S_SCAN;
                end
            end
            S_TOPR:
            begin
                if (sp_reg == '0)
                begin
                    if (last_c && last_r)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        if (last_c)
                        begin
                            sc_next = '0;
                            sr_next = sr_reg + 1'b1;
                        end
                        else
                        begin
                            sc_next = sc_reg + 1'b1;
                        end
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_TOPW;
                end
            end
            S_TOPW:
            begin
                nr_next = stk_rdata[AW+2:CW+3];
                nc_next = stk_rdata[CW+2:3];
                if (stk_rdata[2:0] >= gscd_pkg::DIR_DONE)
                begin
                    flg_waddr = stk_rdata[AW+2:3];
                    flg_we    = 1'b1;
                    flg_wdata = 2'b10;
                    sp_next   = sp_reg - 1'b1;
                    state_next = S_TOPR;
                end
                else
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {stk_rdata[AW+2:3], stk_rdata[2:0] + 3'd1};
                    case (stk_rdata[2:0])
                        gscd_pkg::DIR_UP:
                        begin
                            blocked = stk_rdata[AW+2:CW+3] == '0;
                            nr_next = stk_rdata[AW+2:CW+3] - 1'b1;
                        end
                        gscd_pkg::DIR_DOWN:
                        begin
                            blocked = ({1'b0, stk_rdata[AW+2:CW+3]} + 1'b1) >= rows;
                            nr_next = stk_rdata[AW+2:CW+3] + 1'b1;
                        end
                        gscd_pkg::DIR_LEFT:
                        begin
                            blocked = stk_rdata[CW+2:3] == '0;
                            nc_next = stk_rdata[CW+2:3] - 1'b1;
                        end
                        default:
                        begin
                            blocked = ({1'b0, stk_rdata[CW+2:3]} + 1'b1) >= cols;
                            nc_next = stk_rdata[CW+2:3] + 1'b1;
                        end
                    endcase
                    col_raddr = addr_of(nr_next, nc_next);
                    flg_addr  = addr_of(nr_next, nc_next);
                    state_next = blocked ? S_TOPR : S_NBRW;
                end
            end
            S_NBRW:
            begin
                if (col_rdata != colour_reg || flg_rdata[0])
                begin
                    state_next = S_TOPR;
                end
                else if (flg_rdata[1])
                begin
                    found_next = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    flg_waddr = addr_of(nr_reg, nc_reg);
                    flg_we    = 1'b1;
                    flg_wdata = 2'b11;
                    stk_addr  = sp_reg[AW-1:0];
                    stk_we    = 1'b1;
                    stk_wdata = {nr_reg, nc_reg, gscd_pkg::DIR_UP};
                    sp_next   = sp_reg + 1'b1;
                    state_next = S_TOPR;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done  = done_reg;
    assign found = found_reg;

    `GSC_ASSERT(a_sp_bound, clk, rst_n, sp_reg <= SPW'(DEPTH), "stack pointer overflow")
    `GSC_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "done outside idle")
    `GSC_ASSERT_NEXT(a_start_idle, clk, rst_n, start && state_reg == S_IDLE, state_reg == S_CLEAR, "start not taken")
endmodule
`default_nettype wire

[src/grid_same_colour_cycle_detect.sv]
// ----------------------------------------------------------------------------
// grid_same_colour_cycle_detect
// same-colour cycle detector over a loaded grid of colour codes
// ----------------------------------------------------------------------------
// usage:
//   cells arrive on the input channel (valid/stall), one per cycle while
//   not stalled, in row-major order; each transfer writes one colour into
//   the store; after the transfer of the last cell the input stalls while
//   the search runs: a start, a clearing pass over all rows*cols cells,
//   then a depth-first walk that scans cells, steps to neighbours unless
//   the grid edge blocks them, and pops finished cells; memory reads are
//   registered; at the end of the walk the result passes from the search's
//   done register into the output register
//   a single cycle_found result transfer follows per grid; it is held in
//   the output register until the receiver drops stall; loading of the next
//   grid proceeds meanwhile and only its last cell waits for that transfer
//   a write to grid_rows or grid_cols restarts loading at cell (0,0)
//   reset clears control state; no memory clearing pass is needed at reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_same_colour_cycle_detect_macros.svh"
module grid_same_colour_cycle_detect #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [4:0] cell_colour,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            cycle_found
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [6:0]    rows_cfg_reg, cols_cfg_reg;
    logic [RW:0]   rows_eff;
    logic [CW:0]   cols_eff;
    logic [RW-1:0] lr_reg;
    logic [CW-1:0] lc_reg;
    logic          busy_reg;
    logic          out_valid_reg, found_out_reg;
    logic          in_xfer, last_cell, s_done, s_found;

    // clamp sizes into 2..MAX
    always_comb
    begin
        if (rows_cfg_reg < 7'd2)
            rows_eff = (RW+1)'(2);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = (RW+1)'(MAX_ROWS);
        else
            rows_eff = (RW+1)'(rows_cfg_reg);
        if (cols_cfg_reg < 7'd2)
            cols_eff = (CW+1)'(2);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_eff = (CW+1)'(MAX_COLS);
        else
            cols_eff = (CW+1)'(cols_cfg_reg);
    end

    // hold input off during search, and hold the last cell while a result waits
    assign in_stall  = busy_reg || (out_valid_reg && last_cell);
    assign in_xfer   = in_valid && !in_stall;
    assign last_cell = ({1'b0, lr_reg} + 1'b1 >= rows_eff) &&
                       ({1'b0, lc_reg} + 1'b1 >= cols_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= 7'd64;
            cols_cfg_reg  <= 7'd64;
            lr_reg        <= '0;
            lc_reg        <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            found_out_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lr_reg <= '0;
                lc_reg <= '0;
                if (cfg_index == gscd_pkg::REG_ROWS)
                    rows_cfg_reg <= cfg_data;
                else
                    cols_cfg_reg <= cfg_data;
            end
            else if (in_xfer)
            begin
                if (last_cell)
                begin
                    lr_reg   <= '0;
                    lc_reg   <= '0;
                    busy_reg <= 1'b1;
                end
                else if ({1'b0, lc_reg} + 1'b1 >= cols_eff)
                begin
                    lc_reg <= '0;
                    lr_reg <= lr_reg + 1'b1;
                end
                else
                begin
                    lc_reg <= lc_reg + 1'b1;
                end
            end
            if (s_done)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                found_out_reg <= s_found;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    gscd_search #(.RW(RW), .CW(CW)) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_xfer),
        .wr_addr   ({lr_reg, lc_reg}),
        .wr_colour (cell_colour),
        .start     (in_xfer && last_cell),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .done      (s_done),
        .found     (s_found)
    );

    assign out_valid   = out_valid_reg;
    assign cycle_found = found_out_reg;

    `GSC_ASSERT_IMPL(a_no_in_busy, clk, rst_n, busy_reg, in_stall, "input open during search")
    `GSC_ASSERT_IMPL(a_done_busy, clk, rst_n, s_done, busy_reg, "search done while not busy")
    `GSC_ASSERT_IMPL(a_one_result, clk, rst_n, s_done, !out_valid_reg, "result overwritten")
endmodule
`default_nettype wire
